FILE: rtl/core/lpr_pkg.sv
package lpr_pkg;

   localparam int DEF_COORD_BITS = 12;
   localparam int DEF_COLOR_BITS = 32;

   localparam int CFG_BITS  = 12;
   localparam int ADDR_BITS = 22;
   localparam int LIM_BITS  = 2 * CFG_BITS;

   localparam logic [CFG_BITS-1:0] RESET_ROW_WIDTH    = 12'd640;
   localparam logic [CFG_BITS-1:0] RESET_FRAME_HEIGHT = 12'd480;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

   typedef enum logic {
      REG_ROW_WIDTH    = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

endpackage

FILE: rtl/core/line_pixel_rasterizer.sv
// path: a step word passes the queue and the walk unit, then the a input register, the b
// multiply register and the c add/compare output register; a load word gives no output
// throughput: one word per cycle in while the queue has room, one pixel per cycle out
// while rsp_tready allows, bounded by the combinational bresenham update in the walk unit
// reset: synchronous, clears queue, walk state and pipeline valids;
// row_width returns to 640 and frame_height to 480
module line_pixel_rasterizer
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COLOR_BITS = DEF_COLOR_BITS,
   localparam int IN_W  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((2 * COORD_BITS + ADDR_BITS + COLOR_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_W-1:0]   req_tdata,   // start_x, start_y, end_x, end_y, pen_color
   input  logic              req_tuser,   // action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_tdata,   // pixel_x, pixel_y, pixel_address, pixel_color
   output logic              rsp_tuser,   // write_enable
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int C = COORD_BITS;

   logic [CFG_BITS-1:0] row_width_ff, row_width_in;
   logic [CFG_BITS-1:0] frame_height_ff, frame_height_in;
   reg_index_type       csr_index;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      row_width_in    = row_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ROW_WIDTH:    row_width_in    = csr_pwdata[CFG_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
      unique case (csr_index)
         REG_ROW_WIDTH:    csr_prdata = {{(32 - CFG_BITS){1'b0}}, row_width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {{(32 - CFG_BITS){1'b0}}, frame_height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= RESET_ROW_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else begin
         row_width_ff    <= row_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   logic                  cmd_valid, cmd_ready;
   action_type            cmd_action;
   logic signed [C-1:0]   cmd_cur_x, cmd_cur_y, cmd_goal_x, cmd_goal_y;
   logic [C-1:0]          cmd_span_x, cmd_span_y;
   logic                  cmd_dir_x_neg, cmd_dir_y_neg;
   logic [COLOR_BITS-1:0] cmd_color;

   lpr_front #(
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_action     (action_type'(req_tuser)),
      .in_start_x    (req_tdata[0 +: C]),
      .in_start_y    (req_tdata[C +: C]),
      .in_end_x      (req_tdata[2 * C +: C]),
      .in_end_y      (req_tdata[3 * C +: C]),
      .in_color      (req_tdata[4 * C +: COLOR_BITS]),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd_action    (cmd_action),
      .cmd_cur_x     (cmd_cur_x),
      .cmd_cur_y     (cmd_cur_y),
      .cmd_goal_x    (cmd_goal_x),
      .cmd_goal_y    (cmd_goal_y),
      .cmd_span_x    (cmd_span_x),
      .cmd_span_y    (cmd_span_y),
      .cmd_dir_x_neg (cmd_dir_x_neg),
      .cmd_dir_y_neg (cmd_dir_y_neg),
      .cmd_color     (cmd_color)
   );

   logic                  pix_valid, pix_ready, pix_last;
   logic signed [C-1:0]   pix_x, pix_y;
   logic [COLOR_BITS-1:0] pix_color;

   lpr_walk #(
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd_action    (cmd_action),
      .cmd_cur_x     (cmd_cur_x),
      .cmd_cur_y     (cmd_cur_y),
      .cmd_goal_x    (cmd_goal_x),
      .cmd_goal_y    (cmd_goal_y),
      .cmd_span_x    (cmd_span_x),
      .cmd_span_y    (cmd_span_y),
      .cmd_dir_x_neg (cmd_dir_x_neg),
      .cmd_dir_y_neg (cmd_dir_y_neg),
      .cmd_color     (cmd_color),
      .pix_valid     (pix_valid),
      .pix_ready     (pix_ready),
      .pix_x         (pix_x),
      .pix_y         (pix_y),
      .pix_last      (pix_last),
      .pix_color     (pix_color)
   );

   logic signed [C-1:0]   out_x, out_y;
   logic [ADDR_BITS-1:0]  out_address;
   logic [COLOR_BITS-1:0] out_color;

   lpr_addr #(
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_addr (
      .clock            (clock),
      .reset            (reset),
      .row_width        (row_width_ff),
      .frame_height     (frame_height_ff),
      .pix_valid        (pix_valid),
      .pix_ready        (pix_ready),
      .pix_x            (pix_x),
      .pix_y            (pix_y),
      .pix_last         (pix_last),
      .pix_color        (pix_color),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_x            (out_x),
      .out_y            (out_y),
      .out_address      (out_address),
      .out_write_enable (rsp_tuser),
      .out_color        (out_color),
      .out_last         (rsp_tlast)
   );

   assign rsp_tdata = {{(OUT_W - 2 * C - ADDR_BITS - COLOR_BITS){1'b0}},
                       out_color, out_address, out_y, out_x};

endmodule

FILE: rtl/core/lpr_front.sv
module lpr_front
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COLOR_BITS = DEF_COLOR_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  action_type                   in_action,
   input  logic signed [COORD_BITS-1:0] in_start_x,
   input  logic signed [COORD_BITS-1:0] in_start_y,
   input  logic signed [COORD_BITS-1:0] in_end_x,
   input  logic signed [COORD_BITS-1:0] in_end_y,
   input  logic [COLOR_BITS-1:0]        in_color,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output action_type                   cmd_action,
   output logic signed [COORD_BITS-1:0] cmd_cur_x,
   output logic signed [COORD_BITS-1:0] cmd_cur_y,
   output logic signed [COORD_BITS-1:0] cmd_goal_x,
   output logic signed [COORD_BITS-1:0] cmd_goal_y,
   output logic [COORD_BITS-1:0]        cmd_span_x,
   output logic [COORD_BITS-1:0]        cmd_span_y,
   output logic                         cmd_dir_x_neg,
   output logic                         cmd_dir_y_neg,
   output logic [COLOR_BITS-1:0]        cmd_color
);

   localparam int C     = COORD_BITS;
   localparam int ENT_W = 1 + 6 * C + 2 + COLOR_BITS;

   logic [ENT_W-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   logic signed [C:0] dx, dy;
   logic [C:0]        abs_x, abs_y;
   logic              neg_x, neg_y;
   logic [ENT_W-1:0]  new_entry, head;
   logic              push, pop;

   always_comb begin
      dx    = {in_end_x[C-1], in_end_x} - {in_start_x[C-1], in_start_x};
      dy    = {in_end_y[C-1], in_end_y} - {in_start_y[C-1], in_start_y};
      abs_x = dx[C] ? (~dx + 1'b1) : dx;
      abs_y = dy[C] ? (~dy + 1'b1) : dy;
      neg_x = dx[C] || (dx == '0);
      neg_y = dy[C] || (dy == '0);
      new_entry = {in_color, neg_y, neg_x, abs_y[C-1:0], abs_x[C-1:0],
                   in_end_y, in_end_x, in_start_y, in_start_x, in_action};
   end

   assign in_ready  = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = cmd_valid && cmd_ready;

   assign head = entry_ff[rd_ptr_ff];
   always_comb begin
      cmd_action    = action_type'(head[0]);
      cmd_cur_x     = head[1 +: C];
      cmd_cur_y     = head[1 + C +: C];
      cmd_goal_x    = head[1 + 2 * C +: C];
      cmd_goal_y    = head[1 + 3 * C +: C];
      cmd_span_x    = head[1 + 4 * C +: C];
      cmd_span_y    = head[1 + 5 * C +: C];
      cmd_dir_x_neg = head[1 + 6 * C];
      cmd_dir_y_neg = head[2 + 6 * C];
      cmd_color     = head[3 + 6 * C +: COLOR_BITS];
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: rtl/core/lpr_walk.sv
module lpr_walk
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COLOR_BITS = DEF_COLOR_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  action_type                   cmd_action,
   input  logic signed [COORD_BITS-1:0] cmd_cur_x,
   input  logic signed [COORD_BITS-1:0] cmd_cur_y,
   input  logic signed [COORD_BITS-1:0] cmd_goal_x,
   input  logic signed [COORD_BITS-1:0] cmd_goal_y,
   input  logic [COORD_BITS-1:0]        cmd_span_x,
   input  logic [COORD_BITS-1:0]        cmd_span_y,
   input  logic                         cmd_dir_x_neg,
   input  logic                         cmd_dir_y_neg,
   input  logic [COLOR_BITS-1:0]        cmd_color,
   output logic                         pix_valid,
   input  logic                         pix_ready,
   output logic signed [COORD_BITS-1:0] pix_x,
   output logic signed [COORD_BITS-1:0] pix_y,
   output logic                         pix_last,
   output logic [COLOR_BITS-1:0]        pix_color
);

   localparam int C = COORD_BITS;

   logic                busy_ff, busy_in;
   logic                end_sent_ff, end_sent_in;
   logic signed [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [C-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [C-1:0]        span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic                dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic signed [C+1:0] err_ff, err_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic signed [C+2:0] e2, sx_w, sy_w, err_next;
   logic                step_x, step_y, done_end, done_walk, fire;
   logic signed [C-1:0] nx, ny;

   always_comb begin
      sx_w     = {3'b000, span_x_ff};
      sy_w     = {3'b000, span_y_ff};
      e2       = {err_ff, 1'b0};
      step_x   = (e2 > -sy_w);
      step_y   = (e2 < sx_w);
      nx       = step_x ? (dir_x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1) : cur_x_ff;
      ny       = step_y ? (dir_y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1) : cur_y_ff;
      err_next = {err_ff[C+1], err_ff} - (step_x ? sy_w : '0) + (step_y ? sx_w : '0);
      done_end  = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);
      done_walk = (nx == goal_x_ff) && (ny == goal_y_ff);
   end

   always_comb begin
      busy_in      = busy_ff;
      end_sent_in  = end_sent_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in       = err_ff;
      color_in     = color_ff;
      cmd_ready    = 1'b0;
      pix_valid    = 1'b0;
      pix_x        = end_sent_ff ? cur_x_ff : goal_x_ff;
      pix_y        = end_sent_ff ? cur_y_ff : goal_y_ff;
      pix_last     = end_sent_ff ? done_walk : done_end;
      pix_color    = color_ff;
      fire         = 1'b0;
      if (cmd_valid) begin
         if (cmd_action == ACT_LOAD) begin
            cmd_ready    = 1'b1;
            busy_in      = 1'b1;
            end_sent_in  = 1'b0;
            cur_x_in     = cmd_cur_x;
            cur_y_in     = cmd_cur_y;
            goal_x_in    = cmd_goal_x;
            goal_y_in    = cmd_goal_y;
            span_x_in    = cmd_span_x;
            span_y_in    = cmd_span_y;
            dir_x_neg_in = cmd_dir_x_neg;
            dir_y_neg_in = cmd_dir_y_neg;
            err_in       = {2'b00, cmd_span_x} - {2'b00, cmd_span_y};
            color_in     = cmd_color;
         end else if (!busy_ff) begin
            cmd_ready = 1'b1;
         end else begin
            pix_valid = 1'b1;
            cmd_ready = pix_ready;
            fire      = pix_ready;
         end
      end
      if (fire) begin
         end_sent_in = 1'b1;
         if (!end_sent_ff) begin
            busy_in = !done_end;
         end else begin
            busy_in  = !done_walk;
            cur_x_in = nx;
            cur_y_in = ny;
            err_in   = err_next[C+1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         end_sent_ff  <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         span_x_ff    <= '0;
         span_y_ff    <= '0;
         dir_x_neg_ff <= 1'b0;
         dir_y_neg_ff <= 1'b0;
         err_ff       <= '0;
         color_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         end_sent_ff  <= end_sent_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         dir_x_neg_ff <= dir_x_neg_in;
         dir_y_neg_ff <= dir_y_neg_in;
         err_ff       <= err_in;
         color_ff     <= color_in;
      end
   end

endmodule

FILE: rtl/core/lpr_addr.sv
module lpr_addr
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COLOR_BITS = DEF_COLOR_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [CFG_BITS-1:0]          row_width,
   input  logic [CFG_BITS-1:0]          frame_height,
   input  logic                         pix_valid,
   output logic                         pix_ready,
   input  logic signed [COORD_BITS-1:0] pix_x,
   input  logic signed [COORD_BITS-1:0] pix_y,
   input  logic                         pix_last,
   input  logic [COLOR_BITS-1:0]        pix_color,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic [ADDR_BITS-1:0]         out_address,
   output logic                         out_write_enable,
   output logic [COLOR_BITS-1:0]        out_color,
   output logic                         out_last
);

   localparam int C     = COORD_BITS;
   localparam int PW    = C + CFG_BITS + 1;
   localparam int LIN_W = (PW + 1 > LIM_BITS + 1) ? PW + 1 : LIM_BITS + 1;

   logic [LIM_BITS-1:0] lim_ff;

   logic                  a_valid_ff, a_valid_in;
   logic signed [C-1:0]   a_x_ff, a_y_ff;
   logic                  a_last_ff;
   logic [COLOR_BITS-1:0] a_color_ff;

   logic                  b_valid_ff, b_valid_in;
   logic signed [PW-1:0]  b_prod_ff, b_prod_in;
   logic signed [C-1:0]   b_x_ff, b_y_ff;
   logic                  b_last_ff;
   logic [COLOR_BITS-1:0] b_color_ff;

   logic                  c_valid_ff, c_valid_in;
   logic signed [C-1:0]   c_x_ff, c_y_ff;
   logic [ADDR_BITS-1:0]  c_addr_ff, c_addr_in;
   logic                  c_we_ff, c_we_in;
   logic                  c_last_ff;
   logic [COLOR_BITS-1:0] c_color_ff;

   logic                  a_ready, b_ready, c_ready;
   logic [LIN_W-1:0]      lin;

   assign c_ready   = !c_valid_ff || out_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign pix_ready = a_ready;

   always_comb begin
      a_valid_in = a_ready ? pix_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      c_valid_in = c_ready ? b_valid_ff : c_valid_ff;
      b_prod_in  = $signed({{(PW - C){a_y_ff[C-1]}}, a_y_ff})
                 * $signed({{(PW - CFG_BITS){1'b0}}, row_width});
      lin        = {{(LIN_W - PW){b_prod_ff[PW-1]}}, b_prod_ff}
                 + {{(LIN_W - C){b_x_ff[C-1]}}, b_x_ff};
      c_addr_in  = lin[ADDR_BITS-1:0];
      c_we_in    = !b_x_ff[C-1] && !b_y_ff[C-1]
                 && (lin < {{(LIN_W - LIM_BITS){1'b0}}, lim_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= {{(LIM_BITS - CFG_BITS){1'b0}}, row_width}
              * {{(LIM_BITS - CFG_BITS){1'b0}}, frame_height};
      if (a_ready) begin
         a_x_ff     <= pix_x;
         a_y_ff     <= pix_y;
         a_last_ff  <= pix_last;
         a_color_ff <= pix_color;
      end
      if (b_ready) begin
         b_prod_ff  <= b_prod_in;
         b_x_ff     <= a_x_ff;
         b_y_ff     <= a_y_ff;
         b_last_ff  <= a_last_ff;
         b_color_ff <= a_color_ff;
      end
      if (c_ready) begin
         c_x_ff     <= b_x_ff;
         c_y_ff     <= b_y_ff;
         c_addr_ff  <= c_addr_in;
         c_we_ff    <= c_we_in;
         c_last_ff  <= b_last_ff;
         c_color_ff <= b_color_ff;
      end
   end

   assign out_valid        = c_valid_ff;
   assign out_x            = c_x_ff;
   assign out_y            = c_y_ff;
   assign out_address      = c_addr_ff;
   assign out_write_enable = c_we_ff;
   assign out_color        = c_color_ff;
   assign out_last         = c_last_ff;

endmodule

FILE: verif/tb_line_pixel_rasterizer.sv
module tb_line_pixel_rasterizer;
   import lpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic [21:0]        address;
      logic               write_enable;
      logic [31:0]        color;
      logic               last;
   } pixel_type;

   class raster_scoreboard;
      logic [11:0]        row_width = RESET_ROW_WIDTH;
      logic [11:0]        frame_height = RESET_FRAME_HEIGHT;
      bit                 busy;
      bit                 end_sent;
      logic signed [11:0] cur_x;
      logic signed [11:0] cur_y;
      logic signed [11:0] goal_x;
      logic signed [11:0] goal_y;
      logic [11:0]        span_x;
      logic [11:0]        span_y;
      bit                 dir_x_neg;
      bit                 dir_y_neg;
      logic signed [13:0] err_acc;
      logic [31:0]        line_color;
      pixel_type          pending_pixels[$];
      int                 failures;

      function void queue_pixel(logic signed [11:0] x, logic signed [11:0] y, bit last);
         longint lin;
         longint limit;
         pixel_type p;
         lin = longint'(y) * longint'(row_width) + longint'(x);
         limit = longint'(row_width) * longint'(frame_height);
         p.x = x;
         p.y = y;
         p.address = lin[21:0];
         p.write_enable = (x >= 0) && (y >= 0) && (lin < limit);
         p.color = line_color;
         p.last = last;
         pending_pixels = {pending_pixels, p};
      endfunction

      function void take_word(action_type act, logic [79:0] data);
         int dx;
         int dy;
         int e2;
         logic signed [11:0] px;
         logic signed [11:0] py;
         bit done;
         if (act == ACT_LOAD) begin
            cur_x = data[11:0];
            cur_y = data[23:12];
            goal_x = data[35:24];
            goal_y = data[47:36];
            dx = int'(goal_x) - int'(cur_x);
            dy = int'(goal_y) - int'(cur_y);
            span_x = 12'(dx < 0 ? -dx : dx);
            span_y = 12'(dy < 0 ? -dy : dy);
            dir_x_neg = !(cur_x < goal_x);
            dir_y_neg = !(cur_y < goal_y);
            err_acc = 14'(int'(span_x) - int'(span_y));
            line_color = data[79:48];
            busy = 1'b1;
            end_sent = 1'b0;
         end else if (busy) begin
            if (!end_sent) begin
               done = (cur_x == goal_x) && (cur_y == goal_y);
               end_sent = 1'b1;
               if (done) busy = 1'b0;
               queue_pixel(goal_x, goal_y, done);
            end else begin
               px = cur_x;
               py = cur_y;
               e2 = 2 * int'(err_acc);
               if (e2 > -int'(span_y)) begin
                  err_acc = 14'(int'(err_acc) - int'(span_y));
                  cur_x = cur_x + (dir_x_neg ? -12'sd1 : 12'sd1);
               end
               if (e2 < int'(span_x)) begin
                  err_acc = 14'(int'(err_acc) + int'(span_x));
                  cur_y = cur_y + (dir_y_neg ? -12'sd1 : 12'sd1);
               end
               done = (cur_x == goal_x) && (cur_y == goal_y);
               if (done) busy = 1'b0;
               queue_pixel(px, py, done);
            end
         end
      endfunction

      function void check_pixel(logic [79:0] data, logic we, logic last);
         pixel_type want;
         pixel_type got;
         got.x = data[11:0];
         got.y = data[23:12];
         got.address = data[45:24];
         got.color = data[77:46];
         got.write_enable = we;
         got.last = last;
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel x %0d y %0d", got.x, got.y);
            failures++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.x !== want.x) begin
            $error("pixel_x expected %0d got %0d", want.x, got.x);
            failures++;
         end
         if (got.y !== want.y) begin
            $error("pixel_y expected %0d got %0d", want.y, got.y);
            failures++;
         end
         if (got.address !== want.address) begin
            $error("pixel_address expected %0d got %0d", want.address, got.address);
            failures++;
         end
         if (got.write_enable !== want.write_enable) begin
            $error("write_enable expected %0d got %0d", want.write_enable, got.write_enable);
            failures++;
         end
         if (got.color !== want.color) begin
            $error("pixel_color expected %h got %h", want.color, got.color);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0d got %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;   // start_x, start_y, end_x, end_y, pen_color
   logic        req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;   // pixel_x, pixel_y, pixel_address, pixel_color
   logic        rsp_tuser;   // write_enable
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   raster_scoreboard sb = new();
   int snd_idle_pct;
   int rcv_idle_pct;
   bit hold_request;
   int stall_count;

   line_pixel_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready) sb.take_word(action_type'(req_tuser), req_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count == STALL_LIMIT) begin
            $display("** line_pixel_rasterizer: FAILED **");
            $finish;
         end
      end
   end

   // receiver, with a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   function automatic int clamp_coord(int v);
      return v < -2048 ? -2048 : (v > 2047 ? 2047 : v);
   endfunction

   task automatic send_word(action_type act, logic [79:0] data);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_line(int x0, int y0, int x1, int y1, logic [31:0] color, int steps);
      send_word(ACT_LOAD, {color, 12'(y1), 12'(x1), 12'(y0), 12'(x0)});
      repeat (steps) send_word(ACT_STEP, {16'($urandom), $urandom, $urandom});
   endtask

   task automatic write_reg(reg_index_type idx, logic [11:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {20'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_ROW_WIDTH) sb.row_width = value;
      else sb.frame_height = value;
   endtask

   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_line(int w, int h, inout int items);
      int x0;
      int y0;
      int x1;
      int y1;
      int dx;
      int dy;
      int span;
      int n;
      int r;
      if ($urandom_range(99) < 70) begin
         x0 = clamp_coord(int'($urandom_range(w + 12)) - 6);
         y0 = clamp_coord(int'($urandom_range(h + 12)) - 6);
      end else begin
         x0 = int'($urandom_range(4095)) - 2048;
         y0 = int'($urandom_range(4095)) - 2048;
      end
      if ($urandom_range(9) == 0) begin
         dx = int'($urandom_range(80)) - 40;
         dy = int'($urandom_range(80)) - 40;
      end else begin
         dx = int'($urandom_range(24)) - 12;
         dy = int'($urandom_range(24)) - 12;
      end
      x1 = clamp_coord(x0 + dx);
      y1 = clamp_coord(y0 + dy);
      dx = x1 > x0 ? x1 - x0 : x0 - x1;
      dy = y1 > y0 ? y1 - y0 : y0 - y1;
      span = (dx > dy ? dx : dy) + 1;
      r = $urandom_range(99);
      if (r < 10) n = span + int'($urandom_range(2, 1));
      else if (r < 22) n = int'($urandom_range(span - 1));
      else n = span;
      send_line(x0, y0, x1, y1, $urandom, n);
      items += 1 + (n < span ? n : span);
   endtask

   initial begin : stimulus
      int items;
      int w;
      int h;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_request = 1'b0;
      snd_idle_pct = 10;
      rcv_idle_pct = 48;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed lines under the reset frame size
      send_word(ACT_STEP, {16'($urandom), $urandom, $urandom});
      send_line(0, 0, 0, 0, 32'h0000_0000, 2);
      send_line(-2048, 2047, 2047, -2048, 32'hFFFF_FFFF, 2);
      send_line(2047, 2047, 2045, 2044, 32'hA5A5_5A5A, 4);
      send_line(700, 1, 703, 2, 32'h1234_5678, 4);
      send_line(-3, 2, 1, -1, $urandom, 5);
      send_line(639, 479, 640, 480, $urandom, 3);
      drain_pixels();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin w = 1; h = 1; end
            1: begin w = 4095; h = 4095; end
            2: begin w = 0; h = 37; end
            3: begin w = 29; h = 0; end
            4: begin w = 640; h = 480; end
            5: begin w = 2048; h = 2048; end
            default: begin
               w = (phase % 2 == 0) ? int'($urandom_range(100, 1)) : int'($urandom_range(4095));
               h = (phase % 2 == 0) ? int'($urandom_range(100, 1)) : int'($urandom_range(4095));
            end
         endcase
         if (phase < 4) begin
            snd_idle_pct = 10;
            rcv_idle_pct = 48;
         end else if (phase < 7) begin
            snd_idle_pct = 48;
            rcv_idle_pct = 10;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         write_reg(REG_ROW_WIDTH, 12'(w));
         write_reg(REG_FRAME_HEIGHT, 12'(h));
         items = 0;
         if (phase == 7) begin
            // stall the output while a long line keeps coming in
            hold_request = 1'b1;
            send_line(0, 0, 60, 25, $urandom, 61);
         end
         while (items < 90) random_line(w, h, items);
         drain_pixels();
      end

      if (sb.failures == 0) begin
         $display("** line_pixel_rasterizer: PASSED **");
      end else begin
         $display("** line_pixel_rasterizer: FAILED **");
      end
      $finish;
   end

endmodule

FILE: line_pixel_rasterizer.f
rtl/core/lpr_pkg.sv
rtl/core/lpr_front.sv
rtl/core/lpr_walk.sv
rtl/core/lpr_addr.sv
rtl/core/line_pixel_rasterizer.sv
verif/tb_line_pixel_rasterizer.sv
